>>> design/mmt_pkg.sv
// Shared constants, codes and types for the monthly mean tracker.
// No dependencies; every design file refers to it by scoped names.
package mmt_pkg;

  localparam int MONTHS  = 12;
  localparam int ADDR_W  = (MONTHS > 1) ? $clog2(MONTHS) : 1;
  localparam int MON_W   = 4;
  localparam int YEAR_W  = 7;
  localparam int SMP_W   = 16;
  localparam int SUM_W   = 32;
  localparam int CNT_W   = 16;
  localparam int MEAN_W  = 15;
  localparam int STEP_W  = $clog2(SUM_W);

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Control word from the sequencer to the mean tables.
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic              clr_all;
    logic              clr_bank;
    logic              bank;
    logic [ADDR_W-1:0] addr;
  } tbl_ctl_t;

endpackage

>>> design/mmt_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on mmt_pkg for operand widths.
module mmt_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [mmt_pkg::SUM_W-1:0] dividend,
  input  logic [mmt_pkg::CNT_W-1:0] divisor,
  output logic                      done,
  output logic [mmt_pkg::SUM_W-1:0] quotient
);

  logic [mmt_pkg::CNT_W-1:0]  rem;
  logic [mmt_pkg::CNT_W-1:0]  dsr;
  logic [mmt_pkg::STEP_W-1:0] step;
  logic                       busy;
  logic [mmt_pkg::CNT_W+1:0]  diff;
  logic                       ge;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign diff = {1'b0, rem, quotient[mmt_pkg::SUM_W-1]} - {2'b00, dsr};
  assign ge   = ~diff[mmt_pkg::CNT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == mmt_pkg::STEP_W'(mmt_pkg::SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[mmt_pkg::SUM_W-2:0], ge};
      rem      <= ge ? diff[mmt_pkg::CNT_W-1:0]
                     : {rem[mmt_pkg::CNT_W-2:0], quotient[mmt_pkg::SUM_W-1]};
    end
  end

endmodule

>>> design/mmt_table.sv
// Two banks of monthly means; one bank is this year, the other last year.
// Per-entry valid bits stand in for clearing. Depends on mmt_pkg.
module mmt_table (
  input  logic                       clk,
  input  logic                       rst,
  input  mmt_pkg::tbl_ctl_t          ctl,
  input  logic [mmt_pkg::MEAN_W-1:0] wr_data,
  output logic [mmt_pkg::MEAN_W-1:0] rd_data
);

  logic [mmt_pkg::MEAN_W-1:0] mem [2][mmt_pkg::MONTHS];
  logic [mmt_pkg::MONTHS-1:0] vld [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= '0;
      vld[1] <= '0;
    end else begin
      if (ctl.clr_all) begin
        vld[0] <= '0;
        vld[1] <= '0;
      end else if (ctl.clr_bank) begin
        vld[ctl.bank] <= '0;
      end else if (ctl.wr_en) begin
        vld[ctl.bank][ctl.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.bank][ctl.addr] <= wr_data;
    end
  end

  // An entry never written since its last clear reads as zero.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= vld[ctl.bank][ctl.addr] ? mem[ctl.bank][ctl.addr] : '0;
    end
  end

endmodule

>>> design/monthly_mean_tracker.sv
// Top level of the monthly mean tracker: sequencer, sum/count state, output register.
// Depends on mmt_pkg, mmt_div and mmt_table.
//
//  channel | dir | handshake          | contents
//  --------+-----+--------------------+-----------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tdata: sample, month, year; tuser: op, qual, prev
//  m_*     | out | m_tvalid/m_tready  | tdata: mean_value; tuser: updated, m/y rolled
//
// After its accept, a qualified sample in the held month loads the divider, runs the
// bit-serial divider (one quotient bit per cycle), writes the table and hands off to
// the output register. A read passes through S_RD for the registered table read;
// every other word goes straight to S_FIN. rst is synchronous, holds s_tready low and
// clears all control state and the table valid bits at once. One word is in flight at a
// time; the next word is accepted while a finished result still waits in the output
// register, and a later result holds in S_FIN until that register frees up.
module monthly_mean_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] sample, [19:16] month, [26:20] year, rest zero
  input  logic [3:0]  s_tuser,   // [1:0] operation, [2] qualify, [3] previous_year_select
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [14:0] mean_value, [15] zero
  output logic [2:0]  m_tuser    // [0] mean_updated, [1] month_rolled, [2] year_rolled
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_RD   = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state;

  // Input word fields.
  logic [1:0]                 op;
  logic [mmt_pkg::SMP_W-1:0]  sample;
  logic                       qualify;
  logic [mmt_pkg::MON_W-1:0]  month;
  logic [mmt_pkg::YEAR_W-1:0] year;
  logic                       prev_sel;

  assign sample   = s_tdata[15:0];
  assign month    = s_tdata[19:16];
  assign year     = s_tdata[26:20];
  assign op       = s_tuser[1:0];
  assign qualify  = s_tuser[2];
  assign prev_sel = s_tuser[3];

  // Tracker state.
  logic [mmt_pkg::SUM_W-1:0]  running_sum;
  logic [mmt_pkg::CNT_W-1:0]  sample_count;
  logic [mmt_pkg::MON_W-1:0]  held_month;
  logic [mmt_pkg::YEAR_W-1:0] held_year;
  logic                       started;
  logic                       this_bank;   // bank that holds this year's means

  // Result staging.
  logic [mmt_pkg::MEAN_W-1:0] res_value;
  logic                       res_upd;
  logic                       res_mr;
  logic                       res_yr;

  logic                       div_start;
  logic                       div_done;
  logic [mmt_pkg::SUM_W-1:0]  quotient;
  mmt_pkg::tbl_ctl_t          tbl_ctl;
  logic [mmt_pkg::MEAN_W-1:0] rd_data;

  logic                       accept;
  logic                       mon_ok;
  logic [mmt_pkg::MON_W-1:0]  mon_m1;
  logic [mmt_pkg::MON_W-1:0]  held_m1;
  logic [mmt_pkg::CNT_W-1:0]  clamped;
  logic                       same_month;
  logic                       year_change;
  logic                       can_acc;
  logic                       out_free;

  assign s_tready    = (state == S_IDLE) & ~rst;
  assign accept      = s_tvalid & s_tready;
  assign mon_ok      = (month != '0) &&
                       ({1'b0, month} <= (mmt_pkg::MON_W + 1)'(mmt_pkg::MONTHS));
  assign mon_m1      = month - mmt_pkg::MON_W'(1);
  assign held_m1     = held_month - mmt_pkg::MON_W'(1);
  // Negative samples count as zero.
  assign clamped     = sample[mmt_pkg::SMP_W-1] ? '0 : sample;
  assign same_month  = (held_month == month);
  assign year_change = (held_year != year);
  // A full count drops further samples of the month.
  assign can_acc     = qualify && (sample_count != '1);
  assign out_free    = ~m_tvalid | m_tready;

  // Table control: clears and reads at accept, write when the quotient lands.
  always_comb begin
    tbl_ctl      = '0;
    tbl_ctl.bank = this_bank;
    tbl_ctl.addr = mon_m1[mmt_pkg::ADDR_W-1:0];
    if (accept) begin
      unique case (op)
        mmt_pkg::OP_SAMPLE: begin
          // Year roll: the old last-year bank becomes this year, emptied.
          if (mon_ok && started && !same_month && year_change) begin
            tbl_ctl.clr_bank = 1'b1;
            tbl_ctl.bank     = ~this_bank;
          end
        end
        mmt_pkg::OP_CLEAR: begin
          tbl_ctl.clr_all = 1'b1;
        end
        mmt_pkg::OP_READ: begin
          tbl_ctl.rd_en = mon_ok;
          tbl_ctl.bank  = prev_sel ? ~this_bank : this_bank;
        end
        default: begin
        end
      endcase
    end else if (state == S_DIV && div_done) begin
      tbl_ctl.wr_en = 1'b1;
      tbl_ctl.addr  = held_m1[mmt_pkg::ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      running_sum  <= '0;
      sample_count <= '0;
      held_month   <= '0;
      held_year    <= '0;
      started      <= 1'b0;
      this_bank    <= 1'b0;
      div_start    <= 1'b0;
      res_value    <= '0;
      res_upd      <= 1'b0;
      res_mr       <= 1'b0;
      res_yr       <= 1'b0;
    end else begin
      div_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_value <= '0;
            res_upd   <= 1'b0;
            res_mr    <= 1'b0;
            res_yr    <= 1'b0;
            state     <= S_FIN;
            unique case (op)
              mmt_pkg::OP_SAMPLE: begin
                if (mon_ok) begin
                  if (!started) begin
                    // First sample only adopts the date.
                    held_month <= month;
                    held_year  <= year;
                    started    <= 1'b1;
                  end else if (same_month) begin
                    if (can_acc) begin
                      running_sum  <= running_sum + mmt_pkg::SUM_W'(clamped);
                      sample_count <= sample_count + 1'b1;
                      div_start    <= 1'b1;
                      state        <= S_DIV;
                    end
                  end else begin
                    // Month change: restart the mean, drop this sample.
                    held_month   <= month;
                    running_sum  <= '0;
                    sample_count <= '0;
                    res_mr       <= 1'b1;
                    if (year_change) begin
                      held_year <= year;
                      this_bank <= ~this_bank;
                      res_yr    <= 1'b1;
                    end
                  end
                end
              end
              mmt_pkg::OP_CLEAR: begin
                running_sum  <= '0;
                sample_count <= '0;
                held_month   <= month;
              end
              mmt_pkg::OP_READ: begin
                if (mon_ok) begin
                  state <= S_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_value <= quotient[mmt_pkg::MEAN_W-1:0];
            res_upd   <= 1'b1;
            state     <= S_FIN;
          end
        end
        S_RD: begin
          res_value <= rd_data;
          state     <= S_FIN;
        end
        S_FIN: begin
          // Hold the result until the output register frees up.
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
      m_tuser  <= '0;
    end else if (state == S_FIN && out_free) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {1'b0, res_value};
      m_tuser  <= {res_yr, res_mr, res_upd};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  mmt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (running_sum),
    .divisor  (sample_count),
    .done     (div_done),
    .quotient (quotient)
  );

  mmt_table u_table (
    .clk     (clk),
    .rst     (rst),
    .ctl     (tbl_ctl),
    .wr_data (quotient[mmt_pkg::MEAN_W-1:0]),
    .rd_data (rd_data)
  );

endmodule
